// ----- src/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helper functions shared by the URL
// percent-decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package upd_pkg;

	// character codes
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// input beat payload
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	// output beat payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       bad_hex;
	} out_beat_t;

	// escape tracking in the front end
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// work classes handed from front to back
	typedef enum logic [1:0] {
		OP_PLAIN = 2'd0,  // ordinary byte, plus may map to space
		OP_ESC   = 2'd1,  // two hex digits to combine
		OP_CUT   = 2'd2   // escape cut short: '%' then a plain byte
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data_a;  // first digit of an escape
		logic [7:0] data_b;  // plain byte or second digit
		logic       last;
		logic       plus;    // query mode at the time of the beat
	} op_t;

	// hex digit value; msb set when the character is not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// ordinary byte, with plus turned to space in query mode
	function automatic logic [7:0] plain_char(input logic [7:0] c, input logic plus);
		logic [7:0] r;
		r = c;
		if (plus && c == CHAR_PLUS) begin
			r = CHAR_SPACE;
		end
		return r;
	endfunction

endpackage

// ----- src/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts input beats, follows the escape state and pushes one work entry
// for every beat that completes a result.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plus_as_space,
	input  logic              in_valid,
	output logic              in_ready,
	input  upd_pkg::in_beat_t in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output upd_pkg::op_t      push_op
);

	upd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      first_q;
	logic            in_fire;
	logic            emit;

	assign in_ready = push_ready;
	assign in_fire  = in_valid && in_ready;

	// classify the beat against the escape state
	always_comb begin
		phase_d        = phase_q;
		emit           = 1'b0;
		push_op.kind   = upd_pkg::OP_PLAIN;
		push_op.data_a = first_q;
		push_op.data_b = in_data.in_byte;
		push_op.last   = in_data.in_last;
		push_op.plus   = plus_as_space;
		unique case (phase_q)
			upd_pkg::PH_PCT: begin
				if (in_data.in_last) begin
					emit         = 1'b1;
					push_op.kind = upd_pkg::OP_CUT;
					phase_d      = upd_pkg::PH_IDLE;
				end else begin
					phase_d = upd_pkg::PH_DIGIT;
				end
			end
			upd_pkg::PH_DIGIT: begin
				emit         = 1'b1;
				push_op.kind = upd_pkg::OP_ESC;
				phase_d      = upd_pkg::PH_IDLE;
			end
			default: begin
				if (in_data.in_byte == upd_pkg::CHAR_PCT && !in_data.in_last) begin
					phase_d = upd_pkg::PH_PCT;
				end else begin
					emit    = 1'b1;
					phase_d = upd_pkg::PH_IDLE;
				end
			end
		endcase
	end

	assign push_valid = in_valid && emit;

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
		end else if (in_fire) begin
			phase_q <= phase_d;
		end
	end

	// held first digit
	always_ff @(posedge clk) begin
		if (in_fire && phase_q == upd_pkg::PH_PCT) begin
			first_q <= in_data.in_byte;
		end
	end

	// an accepted second digit always yields an entry
	a_digit_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == upd_pkg::PH_DIGIT) |-> (push_valid && push_op.kind == upd_pkg::OP_ESC))
		else $error("second digit did not push an escape entry");

	// a pending escape goes back to idle once the digit phase is consumed
	a_digit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == upd_pkg::PH_DIGIT) |=> phase_q == upd_pkg::PH_IDLE)
		else $error("escape state not cleared after second digit");

endmodule

// ----- src/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  upd_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output upd_pkg::op_t pop_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	upd_pkg::op_t  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_fire;
	logic          pop_fire;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_op     = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

endmodule

// ----- src/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Turns work entries into result beats and holds them in the output
// register; an escape cut short gives two beats from one entry.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  upd_pkg::op_t       op,
	output logic               out_valid,
	input  logic               out_ready,
	output upd_pkg::out_beat_t out_data
);

	upd_pkg::out_beat_t res;
	upd_pkg::out_beat_t out_q;
	logic               out_valid_q;
	logic               half_q;
	logic               load;
	logic [4:0]         hi_nib;
	logic [4:0]         lo_nib;

	assign load     = !out_valid_q || out_ready;
	assign op_ready = load && (op.kind != upd_pkg::OP_CUT || half_q);
	assign hi_nib   = upd_pkg::hex_nibble(op.data_a);
	assign lo_nib   = upd_pkg::hex_nibble(op.data_b);

	// result for the entry at the head of the queue
	always_comb begin
		res.out_byte = upd_pkg::plain_char(op.data_b, op.plus);
		res.out_last = op.last;
		res.bad_hex  = 1'b0;
		unique case (op.kind)
			upd_pkg::OP_ESC: begin
				res.bad_hex  = hi_nib[4] | lo_nib[4];
				res.out_byte = (hi_nib[4] | lo_nib[4]) ? 8'h00 : {hi_nib[3:0], lo_nib[3:0]};
			end
			upd_pkg::OP_CUT: begin
				if (!half_q) begin
					res.out_byte = upd_pkg::CHAR_PCT;
					res.out_last = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// output register and cut-escape half flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= op_valid;
			if (op_valid && op.kind == upd_pkg::OP_CUT) begin
				half_q <= !half_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && op_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// second half of a cut escape only while that entry waits at the head
	a_half_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (op_valid && op.kind == upd_pkg::OP_CUT))
		else $error("half flag set without a cut escape at the head");

	// an error beat carries a zero byte
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_hex) |-> out_q.out_byte == 8'h00)
		else $error("error beat with non-zero byte");

endmodule

// ----- src/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-decoder: one encoded byte per input beat, decoded
// bytes out, with an error flag for bad hex escapes and a last marker.
//
//   port group | dir | payload          | notes
//   in_*       | in  | upd_pkg::in_beat_t  | one raw byte, last flag
//   out_*      | out | upd_pkg::out_beat_t | decoded byte, last, bad_hex
//   cfg_*      | in  | 1 bit plus_as_space | always ready
//
// One input beat per cycle while the queue has room; a result is offered once its
// completing beat has passed through a queue slot and the output register.
// A '%' and one byte ending the string give two results from one entry, which
// the back end delivers one after the other while the queue holds later entries.
// Input stalls only when the QUEUE_DEPTH-entry queue is full.
// Reset clears the escape state, queue and output valid; mode is path.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  upd_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output upd_pkg::out_beat_t out_data
);

	logic         plus_q;
	logic         push_valid;
	logic         push_ready;
	upd_pkg::op_t push_op;
	logic         pop_valid;
	logic         pop_ready;
	upd_pkg::op_t pop_op;

	// mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= 1'b0;
		end else if (cfg_valid) begin
			plus_q <= cfg_data;
		end
	end

	// classify
	upd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.plus_as_space(plus_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_op      (push_op)
	);

	// decouple
	upd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op   (push_op),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op)
	);

	// decode and deliver
	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (pop_valid),
		.op_ready (pop_ready),
		.op       (pop_op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
